### src/hdma_pkg.sv
`default_nettype none

package hdma_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CFG_BYTES_PER_WRITE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VISIBLE_LINES = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_REGISTER = 2'd2;

  localparam logic [1:0] BPW_RESET = 2'd1;
  localparam logic [1:0] BPW_PAIR = 2'd2;
  localparam logic [7:0] VISIBLE_RESET = 8'd224;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  localparam logic [7:0] HDR_REPEAT_BIT = 8'h80;
  localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
  localparam logic [7:0] FULL_COUNT = 8'h80;

  typedef struct packed {
    logic [1:0] bytes_per_write;
    logic [7:0] visible_lines;
    logic       target_register;
  } cfg_t;

  typedef struct packed {
    logic [7:0] line_count;
    logic [7:0] lines_left;
    logic       repeat_mode;
    logic [1:0] phase;
    logic [7:0] low_hold;
    logic       finished;
  } walk_t;

  typedef struct packed {
    logic [7:0]  row;
    logic [15:0] value;
    logic        target;
  } wr_t;

  localparam walk_t WALK_CLEAR = '{
    line_count:  8'd0,
    lines_left:  8'd0,
    repeat_mode: 1'b0,
    phase:       PH_HEADER,
    low_hold:    8'd0,
    finished:    1'b0
  };

endpackage

`default_nettype wire

### src/hdma_tbl_if.sv
`default_nettype none

interface hdma_tbl_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       table_start;

  modport source (output valid, output table_byte, output table_start, input ready);
  modport sink (input valid, input table_byte, input table_start, output ready);
endinterface

`default_nettype wire

### src/hdma_wr_if.sv
`default_nettype none

interface hdma_wr_if;
  logic        valid;
  logic        ready;
  logic [7:0]  row;
  logic [15:0] value;
  logic        target;

  modport source (output valid, output row, output value, output target, input ready);
  modport sink (input valid, input row, input value, input target, output ready);
endinterface

`default_nettype wire

### src/hdma_step.sv
`default_nettype none

module hdma_step (
  input  hdma_pkg::walk_t st_i,
  input  hdma_pkg::cfg_t  cfg_i,
  input  logic [7:0]      table_byte_i,
  input  logic            table_start_i,
  output hdma_pkg::walk_t st_o,
  output logic            emit_o,
  output hdma_pkg::wr_t   wr_o
);
  import hdma_pkg::*;

  walk_t      cur;
  logic       pair;
  logic [15:0] val;
  logic [8:0] sum;
  logic [7:0] nxt_line;

  always_comb begin
    cur = table_start_i ? WALK_CLEAR : st_i;
    pair = (cfg_i.bytes_per_write == BPW_PAIR);
    st_o = cur;
    emit_o = 1'b0;
    val = 16'd0;
    sum = {1'b0, cur.line_count} + {1'b0, cur.lines_left};
    nxt_line = cur.line_count;

    if (cur.finished) begin
      st_o.finished = 1'b1;
    end else if (cur.line_count >= cfg_i.visible_lines) begin
      st_o.finished = 1'b1;
    end else begin
      unique case (cur.phase)
        PH_HEADER: begin
          if (table_byte_i == 8'd0) begin
            st_o.finished = 1'b1;
          end else begin
            st_o.repeat_mode = |(table_byte_i & HDR_REPEAT_BIT);
            st_o.lines_left = ((table_byte_i & HDR_COUNT_MASK) == 8'd0) ?
                              FULL_COUNT : (table_byte_i & HDR_COUNT_MASK);
            st_o.phase = PH_DATA;
          end
        end
        PH_DATA: begin
          if (pair) begin
            st_o.low_hold = table_byte_i;
            st_o.phase = PH_HIGH;
          end else begin
            emit_o = 1'b1;
            val = {8'd0, table_byte_i};
          end
        end
        default: begin
          emit_o = 1'b1;
          val = pair ? {table_byte_i, cur.low_hold} : {8'd0, table_byte_i};
        end
      endcase
    end

    if (emit_o) begin
      if (cur.repeat_mode) begin
        nxt_line = cur.line_count + 8'd1;
        st_o.lines_left = cur.lines_left - 8'd1;
        st_o.phase = (cur.lines_left == 8'd1) ? PH_HEADER : PH_DATA;
      end else begin
        nxt_line = (sum > {1'b0, cfg_i.visible_lines}) ? cfg_i.visible_lines : sum[7:0];
        st_o.lines_left = 8'd0;
        st_o.phase = PH_HEADER;
      end
      st_o.line_count = nxt_line;
      if (nxt_line >= cfg_i.visible_lines) begin
        st_o.finished = 1'b1;
      end
    end

    wr_o.row = cur.line_count;
    wr_o.value = val;
    wr_o.target = cfg_i.target_register;
  end

endmodule

`default_nettype wire

### src/hdma_direct_table_walker.sv
`default_nettype none

// Walks an HDMA direct-mode table one byte per word and produces line-register writes,
// each tagged with the screen line on which it is first seen. A word with table_start
// set begins a new table and is itself taken as the first header. The walker accepts
// one table word every cycle: the whole header or data step is done in the cycle the
// word is accepted, and a write appears on the output in the next cycle from a result
// register. Input is held off only while a write waits in that register and the
// receiver is not ready to take it. Configuration is to be written through the plain
// write port only while the walker is idle; the block itself does not enforce this.
module hdma_direct_table_walker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hdma_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [hdma_pkg::CfgDataW-1:0]   cfg_wdata_i,
  hdma_tbl_if.sink                        tbl_i,
  hdma_wr_if.source                       wr_o
);
  import hdma_pkg::*;

  cfg_t  cfg_q;
  walk_t st_q;
  walk_t st_d;
  logic  emit;
  wr_t   wr_d;
  wr_t   wr_q;
  logic  out_valid_q;
  logic  accept;

  assign tbl_i.ready = !out_valid_q || wr_o.ready;
  assign accept = tbl_i.valid && tbl_i.ready;

  hdma_step u_step (
    .st_i          (st_q),
    .cfg_i         (cfg_q),
    .table_byte_i  (tbl_i.table_byte),
    .table_start_i (tbl_i.table_start),
    .st_o          (st_d),
    .emit_o        (emit),
    .wr_o          (wr_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_write <= BPW_RESET;
      cfg_q.visible_lines <= VISIBLE_RESET;
      cfg_q.target_register <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BYTES_PER_WRITE: cfg_q.bytes_per_write <= cfg_wdata_i[1:0];
        CFG_VISIBLE_LINES:   cfg_q.visible_lines <= cfg_wdata_i;
        CFG_TARGET_REGISTER: cfg_q.target_register <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= WALK_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        st_q <= st_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (wr_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      wr_q <= wr_d;
    end
  end

  assign wr_o.valid = out_valid_q;
  assign wr_o.row = wr_q.row;
  assign wr_o.value = wr_q.value;
  assign wr_o.target = wr_q.target;

endmodule

`default_nettype wire

### tb/sv/hdma_direct_table_walker_tb.sv
`timescale 1ns / 100ps

module hdma_direct_table_walker_tb;
  import hdma_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_GAP = 13;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned NUM_PHASES = 12;
  localparam int unsigned WORDS_PER_PHASE = 118;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WRITE} check_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [7:0]         data;
    logic               start;
    check_e             chk;
    logic [7:0]         row;
    logic [15:0]        value;
  } table_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  hdma_tbl_if tbl ();
  hdma_wr_if  wr ();

  hdma_direct_table_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tbl_i       (tbl),
    .wr_o        (wr)
  );

  cfg_t        regs;
  walk_t       walk;
  wr_t         pending_writes[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          calm;
  bit          stall_req;

  // Directed table: the reset configuration first, then pairs, odd widths and the limit.
  table_row_t directed [32] = '{
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h01, 1'b1, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'hab, 1'b0, CHK_WRITE, 8'd0,   16'h00ab},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h83, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h00, 1'b0, CHK_WRITE, 8'd1,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'hff, 1'b0, CHK_WRITE, 8'd2,   16'h00ff},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h7f, 1'b0, CHK_WRITE, 8'd3,   16'h007f},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h80, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h55, 1'b0, CHK_WRITE, 8'd4,   16'h0055},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h00, 1'b1, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h12, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h7f, 1'b1, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h01, 1'b0, CHK_WRITE, 8'd0,   16'h0001},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h7f, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h02, 1'b0, CHK_WRITE, 8'd127, 16'h0002},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h05, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h80, 1'b1, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h80, 1'b0, CHK_MODEL, 8'd0,   16'h0000},
    '{ROW_CFG,  CFG_BYTES_PER_WRITE, 8'hfe, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h81, 1'b1, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h34, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h12, 1'b0, CHK_WRITE, 8'd0,   16'h1234},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h01, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'hcd, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h02, 1'b1, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'hff, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_CFG,  CFG_BYTES_PER_WRITE, 8'hff, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h77, 1'b0, CHK_WRITE, 8'd0,   16'h0077},
    '{ROW_CFG,  CFG_VISIBLE_LINES,   8'h01, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h44, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_CFG,  CFG_TARGET_REGISTER, 8'hff, 1'b0, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'h81, 1'b1, CHK_NONE,  8'd0,   16'h0000},
    '{ROW_WORD, CFG_BYTES_PER_WRITE, 8'hee, 1'b0, CHK_MODEL, 8'd0,   16'h0000}
  };

  // Settings for the random phases; the phases after these draw their own.
  cfg_t phase_cfg [8] = '{
    '{2'd1, 8'd224, 1'b0},
    '{2'd2, 8'd224, 1'b1},
    '{2'd1, 8'd255, 1'b1},
    '{2'd2, 8'd1,   1'b0},
    '{2'd3, 8'd40,  1'b1},
    '{2'd0, 8'd255, 1'b0},
    '{2'd2, 8'd255, 1'b1},
    '{2'd1, 8'd0,   1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Works out the write, if any, that one accepted table word causes.
  function automatic bit walk_byte(input logic [7:0] b, input logic s, output wr_t res);
    logic [7:0]  cnt;
    logic [8:0]  skip_to;
    logic [15:0] val;
    res = '0;
    if (s) walk = WALK_CLEAR;
    if (walk.finished) return 1'b0;
    if (walk.line_count >= regs.visible_lines) begin
      walk.finished = 1'b1;
      return 1'b0;
    end
    if (walk.phase == PH_HEADER) begin
      if (b == 8'h00) begin
        walk.finished = 1'b1;
        return 1'b0;
      end
      walk.repeat_mode = (b & HDR_REPEAT_BIT) != 8'h00;
      cnt = b & HDR_COUNT_MASK;
      walk.lines_left = (cnt == 8'h00) ? FULL_COUNT : cnt;
      walk.phase = PH_DATA;
      return 1'b0;
    end
    if (walk.phase == PH_DATA && regs.bytes_per_write == BPW_PAIR) begin
      walk.low_hold = b;
      walk.phase = PH_HIGH;
      return 1'b0;
    end
    // A high byte seen after the width dropped to one byte is a whole value.
    if (walk.phase != PH_DATA && regs.bytes_per_write == BPW_PAIR) val = {b, walk.low_hold};
    else val = {8'h00, b};
    res.row = walk.line_count;
    res.value = val;
    res.target = regs.target_register;
    if (walk.repeat_mode) begin
      walk.line_count = walk.line_count + 8'd1;
      walk.lines_left = walk.lines_left - 8'd1;
      walk.phase = (walk.lines_left == 8'd0) ? PH_HEADER : PH_DATA;
    end else begin
      skip_to = {1'b0, walk.line_count} + {1'b0, walk.lines_left};
      if (skip_to > {1'b0, regs.visible_lines}) skip_to = {1'b0, regs.visible_lines};
      walk.line_count = skip_to[7:0];
      walk.lines_left = 8'd0;
      walk.phase = PH_HEADER;
    end
    if (walk.line_count >= regs.visible_lines) walk.finished = 1'b1;
    return 1'b1;
  endfunction

  task automatic expect_write(input wr_t w);
    pending_writes = {pending_writes, w};
  endtask

  function automatic logic [7:0] draw_header();
    logic [6:0] cnt;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) cnt = 7'($urandom_range(1, 6));
    else if (r < 92) cnt = 7'($urandom_range(7, 127));
    else cnt = 7'd0;
    return {1'($urandom_range(0, 1)), cnt};
  endfunction

  task automatic send_word(input logic [7:0] b, input logic s, output bit got, output wr_t res);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      tbl.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tbl.valid <= 1'b1;
    tbl.table_byte <= b;
    tbl.table_start <= s;
    do @(posedge clk_i); while (!tbl.ready);
    got = walk_byte(b, s, res);
  endtask

  task automatic wait_idle();
    tbl.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BYTES_PER_WRITE: regs.bytes_per_write = data[1:0];
      CFG_VISIBLE_LINES:   regs.visible_lines = data;
      CFG_TARGET_REGISTER: regs.target_register = data[0];
      default: ;
    endcase
  endtask

  // Write sink: random back-pressure per word, one long hold-off on request.
  initial begin : write_sink
    int unsigned gap;
    wr_t         want;
    wr.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall_req) begin
        gap = HOLD_CYCLES;
        stall_req = 1'b0;
      end
      if (gap > 0) begin
        wr.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      wr.ready <= 1'b1;
      do @(posedge clk_i); while (!wr.valid);
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write: expected none, actual row %0d value %h target %b",
                 $time, wr.row, wr.value, wr.target);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        if (wr.row !== want.row) begin
          $display("%0t: row: expected %0d, actual %0d", $time, want.row, wr.row);
          mismatches++;
        end
        if (wr.value !== want.value) begin
          $display("%0t: value: expected %h, actual %h", $time, want.value, wr.value);
          mismatches++;
        end
        if (wr.target !== want.target) begin
          $display("%0t: target: expected %b, actual %b", $time, want.target, wr.target);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    bit          got;
    bit          live;
    wr_t         res;
    cfg_t        setting;
    logic [7:0]  b;
    logic        s;
    int unsigned r;
    int unsigned budget;
    int unsigned live_words;

    mismatches = 0;
    calm = 1'b0;
    stall_req = 1'b0;
    regs = '{bytes_per_write: BPW_RESET, visible_lines: VISIBLE_RESET, target_register: 1'b0};
    walk = WALK_CLEAR;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    tbl.valid <= 1'b0;
    tbl.table_byte <= 8'h00;
    tbl.table_start <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(directed[i].idx, directed[i].data);
      end else begin
        send_word(directed[i].data, directed[i].start, got, res);
        case (directed[i].chk)
          CHK_MODEL: if (got) expect_write(res);
          CHK_WRITE: expect_write('{row: directed[i].row,
                                    value: directed[i].value, target: 1'b0});
          default: ;
        endcase
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p < 8) begin
        setting = phase_cfg[p];
      end else begin
        setting.bytes_per_write = 2'($urandom_range(0, 3));
        setting.visible_lines = 8'($urandom_range(1, 255));
        setting.target_register = 1'($urandom_range(0, 1));
      end
      cfg_write(CFG_BYTES_PER_WRITE, {6'($urandom_range(0, 63)), setting.bytes_per_write});
      cfg_write(CFG_VISIBLE_LINES, setting.visible_lines);
      cfg_write(CFG_TARGET_REGISTER, {7'($urandom_range(0, 127)), setting.target_register});
      calm = (p % 4 == 3);
      if (p == 1 || p == 6) stall_req = 1'b1;
      budget = (setting.visible_lines == 8'd0) ? 15 : WORDS_PER_PHASE;
      live_words = 0;
      while (live_words < budget) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          b = 8'($urandom_range(0, 255));
          s = ($urandom_range(0, 3) == 0);
        end else if (walk.finished || r < 8) begin
          b = draw_header();
          s = 1'b1;
        end else if (walk.phase == PH_HEADER) begin
          b = ($urandom_range(0, 9) == 0) ? 8'h00 : draw_header();
          s = 1'b0;
        end else begin
          b = 8'($urandom_range(0, 255));
          s = 1'b0;
        end
        live = s || !walk.finished;
        send_word(b, s, got, res);
        if (got) expect_write(res);
        if (live) live_words++;
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
